// ===== src/cal_pkg.sv =====
package cal_pkg;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_GET    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OOB  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef logic signed [31:0] data_t;
  typedef logic [8:0]         count_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] value;
    logic [7:0]         position;
  } in_t;

  typedef struct packed {
    data_t      data;
    logic [1:0] status;
    count_t     count;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic    latch;      // capture the command word
    logic    res_set;    // load result status, data 0 or -1
    status_e res_status;
    logic    push_wr;    // append value, bump count
    logic    rd_pos;     // read entry at position, arm shift pointer
    logic    cap;        // load result data from read word
    logic    shift_rd;   // read entry at pointer, advance
    logic    shift_wr;   // write last read word one place down
    logic    cnt_dec;    // drop count by one
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] mode;
    logic       full;
    logic       oob;
    logic       ptr_end;
  } sts_t;

endpackage

// ===== src/cal_datapath.sv =====
module cal_datapath #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cal_pkg::in_t  cmd_i,
  input  cal_pkg::ctl_t ctl_i,
  output cal_pkg::sts_t sts_o,
  output cal_pkg::out_t res_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > 8) ? CntW : 8;

  cal_pkg::in_t                 cmd_q;
  logic [CntW-1:0]              count_q;
  logic [CntW-1:0]              ptr_q;
  logic [CntW-1:0]              ptr_dec;
  logic [AW-1:0]                wr_addr_q;
  logic [DATA_WIDTH-1:0]        mem_q [DEPTH];
  logic signed [DATA_WIDTH-1:0] rdata_q;
  logic signed [DATA_WIDTH-1:0] push_word;
  logic [AW-1:0]                rd_addr;
  logic [AW-1:0]                wr_addr;
  logic [DATA_WIDTH-1:0]        wr_data;
  logic                         wr_en;
  logic                         rd_en;
  logic [CmpW-1:0]              pos_ext;
  logic [CmpW-1:0]              cnt_ext;
  cal_pkg::data_t               res_data_q;
  logic [1:0]                   res_status_q;

  assign push_word = DATA_WIDTH'(cmd_q.value);
  assign pos_ext   = CmpW'(cmd_q.position);
  assign cnt_ext   = CmpW'(count_q);
  assign ptr_dec   = ptr_q - CntW'(1);

  assign sts_o.mode    = cmd_q.mode;
  assign sts_o.full    = (count_q == CntW'(DEPTH));
  assign sts_o.oob     = (pos_ext >= cnt_ext);
  assign sts_o.ptr_end = (ptr_q >= count_q);

  always_comb begin
    rd_en   = ctl_i.rd_pos | ctl_i.shift_rd;
    rd_addr = ctl_i.rd_pos ? AW'(cmd_q.position) : ptr_q[AW-1:0];
    wr_en   = ctl_i.push_wr | ctl_i.shift_wr;
    if (ctl_i.push_wr) begin
      wr_addr = count_q[AW-1:0];
      wr_data = push_word;
    end else begin
      wr_addr = wr_addr_q;
      wr_data = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctl_i.push_wr) begin
      count_q <= count_q + CntW'(1);
    end else if (ctl_i.cnt_dec) begin
      count_q <= count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q <= cmd_i;
    end
    if (ctl_i.rd_pos) begin
      ptr_q <= CntW'(cmd_q.position) + CntW'(1);
    end else if (ctl_i.shift_rd) begin
      ptr_q     <= ptr_q + CntW'(1);
      wr_addr_q <= ptr_dec[AW-1:0];
    end
    if (ctl_i.res_set) begin
      res_status_q <= ctl_i.res_status;
      res_data_q   <= (ctl_i.res_status == cal_pkg::ST_OOB) ? '1 : '0;
    end else if (ctl_i.cap) begin
      res_data_q <= cal_pkg::data_t'(rdata_q);
    end
  end

  assign res_o.data   = res_data_q;
  assign res_o.status = res_status_q;
  assign res_o.count  = cal_pkg::count_t'(count_q);

endmodule

// ===== src/cal_ctrl.sv =====
module cal_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output logic          done_o,
  input  cal_pkg::sts_t sts_i,
  output cal_pkg::ctl_t ctl_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CAPT,
    S_SHIFT,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   pend_q, pend_d;
  logic   busy_q, done_q;

  always_comb begin
    ctl_o   = '0;
    state_d = state_q;
    pend_d  = 1'b0;
    case (state_q)
      S_IDLE, S_RESP: begin
        state_d = S_IDLE;
        if (start && !busy_q) begin
          ctl_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl_o.res_set    = 1'b1;
        ctl_o.res_status = cal_pkg::ST_OK;
        state_d          = S_RESP;
        if (sts_i.mode == cal_pkg::MODE_PUSH) begin
          if (sts_i.full) begin
            ctl_o.res_status = cal_pkg::ST_FULL;
          end else begin
            ctl_o.push_wr = 1'b1;
          end
        end else if (sts_i.mode inside {cal_pkg::MODE_GET, cal_pkg::MODE_REMOVE}) begin
          if (sts_i.oob) begin
            ctl_o.res_status = cal_pkg::ST_OOB;
          end else begin
            ctl_o.rd_pos = 1'b1;
            state_d      = S_CAPT;
          end
        end
      end
      S_CAPT: begin
        ctl_o.cap = 1'b1;
        state_d   = (sts_i.mode == cal_pkg::MODE_REMOVE) ? S_SHIFT : S_RESP;
      end
      S_SHIFT: begin
        // write back the word fetched last cycle while fetching the next
        ctl_o.shift_wr = pend_q;
        if (sts_i.ptr_end) begin
          ctl_o.cnt_dec = 1'b1;
          state_d       = S_RESP;
        end else begin
          ctl_o.shift_rd = 1'b1;
          pend_d         = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      busy_q  <= !(state_d inside {S_IDLE, S_RESP});
      done_q  <= (state_d == S_RESP);
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;

endmodule

// ===== src/compacting_array_list.sv =====
// Channel   Ports                    Handshake
// command   cmd_i (mode/value/pos)   taken at an edge with start high and busy low
// result    res_o (data/status/cnt)  done_o high for one cycle, always taken
//
// Push, nop, full push and index errors: result right after the execute state.
// Get: execute, then capture state. Remove: after capture, count - position - 1
// entries moved down one per cycle via the store's single read and write port.
// Reset clears the count only; store contents stay undefined until pushed.
// busy drops in the result cycle, so a new command may be taken there.
// The result side cannot stall.
module compacting_array_list #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  cal_pkg::in_t  cmd_i,
  output logic          done_o,
  output cal_pkg::out_t res_o
);

  cal_pkg::ctl_t ctl;
  cal_pkg::sts_t sts;

  cal_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  cal_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_i),
    .ctl_i  (ctl),
    .sts_o  (sts),
    .res_o  (res_o)
  );

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.push_wr |-> !sts.full)
    else $error("push written into a full list");

  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == cal_pkg::ST_FULL) |-> sts.full)
    else $error("full status reported while list has room");

endmodule
